// ===== sv/kvt_pkg.sv =====
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared constants, status codes, store access types and key normalization
// for the keyed value table.
// ----------------------------------------------------------------------------
package kvt_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 64;
  localparam int KEY_BYTES   = 15;
  localparam int KEY_SLOT    = 15;
  localparam int KEY_W       = 8 * KEY_SLOT;
  localparam int KEY_LOW_W   = 64;
  localparam int KEY_HIGH_W  = 56;
  localparam int VALUE_W     = 64;
  localparam int STATUS_W    = 2;
  localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Stream word layout
  localparam int IN_DATA_W   = KEY_LOW_W + KEY_HIGH_W + VALUE_W;
  localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VALUE_W + 7) / 8) * 8;

  // Request modes
  localparam logic MODE_SET = 1'b0;
  localparam logic MODE_GET = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // Sequencer to store: one read port, one write port
  typedef struct packed {
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [KEY_W-1:0]          wr_key;
    logic signed [VALUE_W-1:0] wr_value;
  } store_req_t;

  // Store to sequencer: registered read data
  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
  } store_rsp_t;

  // Zero every byte from the first zero byte on, and every byte past KEY_BYTES
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_LOW_W-1:0]  lo,
                                                input logic [KEY_HIGH_W-1:0] hi);
    logic [KEY_W-1:0] raw;
    logic [KEY_W-1:0] res;
    logic             ended;
    raw   = {hi, lo};
    res   = '0;
    ended = 1'b0;
    for (int i = 0; i < KEY_SLOT; i++) begin
      if ((i >= KEY_BYTES) || (raw[8*i +: 8] == 8'd0)) begin
        ended = 1'b1;
      end
      res[8*i +: 8] = ended ? 8'd0 : raw[8*i +: 8];
    end
    return res;
  endfunction

endpackage

// ===== sv/kvt_store.sv =====
// ----------------------------------------------------------------------------
// kvt_store
// Name and value memories of the table: one write port and one registered
// read port, both addressed by the scan sequencer.
// ----------------------------------------------------------------------------
module kvt_store (
  input  logic                clk_i,
  input  kvt_pkg::store_req_t req_i,
  output kvt_pkg::store_rsp_t rsp_o
);

  logic [kvt_pkg::KEY_W-1:0]          key_mem [kvt_pkg::MAX_ENTRIES];
  logic signed [kvt_pkg::VALUE_W-1:0] val_mem [kvt_pkg::MAX_ENTRIES];
  logic [kvt_pkg::KEY_W-1:0]          rd_key_q;
  logic signed [kvt_pkg::VALUE_W-1:0] rd_val_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      key_mem[req_i.wr_addr] <= req_i.wr_key;
      val_mem[req_i.wr_addr] <= req_i.wr_value;
    end
  end

  // Read one entry, data registered
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_key_q <= key_mem[req_i.rd_addr];
      rd_val_q <= val_mem[req_i.rd_addr];
    end
  end

  assign rsp_o.key   = rd_key_q;
  assign rsp_o.value = rd_val_q;

endmodule

// ===== sv/kvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// kvt_ctrl
// Scan sequencer: takes one request word, walks the stored names one per
// cycle through a shared key comparator, then updates, appends or answers,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module kvt_ctrl (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request side
  input  logic                                 req_valid_i,
  output logic                                 req_ready_o,
  input  logic                                 mode_i,
  input  logic [kvt_pkg::KEY_LOW_W-1:0]        key_low_i,
  input  logic [kvt_pkg::KEY_HIGH_W-1:0]       key_high_i,
  input  logic signed [kvt_pkg::VALUE_W-1:0]   value_i,
  // result side
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output logic [kvt_pkg::STATUS_W-1:0]         status_o,
  output logic signed [kvt_pkg::VALUE_W-1:0]   read_value_o,
  // store port
  output kvt_pkg::store_req_t                  store_req_o,
  input  kvt_pkg::store_rsp_t                  store_rsp_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [kvt_pkg::CNT_W-1:0] CNT_FULL = kvt_pkg::CNT_W'(kvt_pkg::MAX_ENTRIES);

  logic [1:0]                         state_q, state_d;
  logic                               mode_q, mode_d;
  logic [kvt_pkg::KEY_W-1:0]          key_q, key_d;
  logic signed [kvt_pkg::VALUE_W-1:0] val_q, val_d;
  logic [kvt_pkg::CNT_W-1:0]          idx_q, idx_d;
  logic                               pend_q, pend_d;
  logic [kvt_pkg::ADDR_W-1:0]         cmp_idx_q, cmp_idx_d;
  logic [kvt_pkg::CNT_W-1:0]          count_q, count_d;
  logic [kvt_pkg::STATUS_W-1:0]       res_st_q, res_st_d;
  logic signed [kvt_pkg::VALUE_W-1:0] res_val_q, res_val_d;
  logic                               out_valid_q;
  logic [kvt_pkg::STATUS_W-1:0]       out_st_q;
  logic signed [kvt_pkg::VALUE_W-1:0] out_val_q;
  logic                               hit;
  logic                               out_load;

  // Shared comparator against the entry read last cycle
  assign hit = pend_q && (store_rsp_i.key == key_q);

  assign req_ready_o = (state_q == S_IDLE);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    key_d     = key_q;
    val_d     = val_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    cmp_idx_d = cmp_idx_q;
    count_d   = count_q;
    res_st_d  = res_st_q;
    res_val_d = res_val_q;
    out_load  = 1'b0;
    store_req_o = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          mode_d  = mode_i;
          key_d   = kvt_pkg::norm_key(key_low_i, key_high_i);
          val_d   = value_i;
          idx_d   = '0;
          pend_d  = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          // Match: answer a get, overwrite on a set
          res_st_d  = kvt_pkg::ST_FOUND;
          res_val_d = (mode_q == kvt_pkg::MODE_GET) ? store_rsp_i.value : '0;
          if (mode_q == kvt_pkg::MODE_SET) begin
            store_req_o.wr_en    = 1'b1;
            store_req_o.wr_addr  = cmp_idx_q;
            store_req_o.wr_key   = key_q;
            store_req_o.wr_value = val_q;
          end
          pend_d  = 1'b0;
          state_d = S_FIN;
        end else if (!pend_q && (idx_q == count_q)) begin
          // Every entry seen without a match
          res_val_d = '0;
          if (mode_q == kvt_pkg::MODE_GET) begin
            res_st_d = kvt_pkg::ST_NOT_FOUND;
          end else if (count_q == CNT_FULL) begin
            res_st_d = kvt_pkg::ST_FULL;
          end else begin
            res_st_d             = kvt_pkg::ST_INSERTED;
            store_req_o.wr_en    = 1'b1;
            store_req_o.wr_addr  = count_q[kvt_pkg::ADDR_W-1:0];
            store_req_o.wr_key   = key_q;
            store_req_o.wr_value = val_q;
            count_d              = count_q + 1'b1;
          end
          state_d = S_FIN;
        end else if (idx_q < count_q) begin
          // Fetch the next entry
          store_req_o.rd_en   = 1'b1;
          store_req_o.rd_addr = idx_q[kvt_pkg::ADDR_W-1:0];
          cmp_idx_d           = idx_q[kvt_pkg::ADDR_W-1:0];
          idx_d               = idx_q + 1'b1;
          pend_d              = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end
      S_FIN: begin
        // Hand over once the output register is free
        if (!out_valid_q || res_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Request payload and pending result
  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    key_q     <= key_d;
    val_q     <= val_d;
    cmp_idx_q <= cmp_idx_d;
    res_st_q  <= res_st_d;
    res_val_q <= res_val_d;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_st_q  <= res_st_q;
      out_val_q <= res_val_q;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign status_o     = out_st_q;
  assign read_value_o = out_val_q;

endmodule

// ===== sv/keyed_value_table.sv =====
// ----------------------------------------------------------------------------
// keyed_value_table
// Associative table of up to 64 named signed 64-bit values, searched by a
// linear scan over a name memory; set updates or appends, get looks up.
// ----------------------------------------------------------------------------
// The scan reads one stored name per cycle from the single read port and
//   checks it in the one shared key comparator; a match at entry i ends it
//   early, a miss walks all n entries held (0 to 64).
// A word is accepted only in the idle state, once the previous result has
//   gone to the output register, which waits while the previous result word
//   stalls; s_axis_tready is low during a scan. Reset: rst_ni clears the
//   entry count and all handshakes; memories need no clearing.
module keyed_value_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: key_low[63:0], key_high[119:64], value[183:120]
  input  logic [kvt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: mode[0]
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: read_value[63:0]
  output logic [kvt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // tuser: status[1:0]
  output logic [kvt_pkg::STATUS_W-1:0]       m_axis_tuser
);

  localparam int HI_LSB  = kvt_pkg::KEY_LOW_W;
  localparam int VAL_LSB = kvt_pkg::KEY_LOW_W + kvt_pkg::KEY_HIGH_W;

  kvt_pkg::store_req_t                store_req;
  kvt_pkg::store_rsp_t                store_rsp;
  logic signed [kvt_pkg::VALUE_W-1:0] read_value;

  // Sequencer and output register
  kvt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .mode_i       (s_axis_tuser[0]),
    .key_low_i    (s_axis_tdata[kvt_pkg::KEY_LOW_W-1:0]),
    .key_high_i   (s_axis_tdata[HI_LSB +: kvt_pkg::KEY_HIGH_W]),
    .value_i      (s_axis_tdata[VAL_LSB +: kvt_pkg::VALUE_W]),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .status_o     (m_axis_tuser),
    .read_value_o (read_value),
    .store_req_o  (store_req),
    .store_rsp_i  (store_rsp)
  );

  // Name and value memories
  kvt_store u_store (
    .clk_i (clk_i),
    .req_i (store_req),
    .rsp_o (store_rsp)
  );

  assign m_axis_tdata = kvt_pkg::OUT_TDATA_W'(unsigned'(read_value));

endmodule

// ===== sv/kvt_checker.sv =====
// ----------------------------------------------------------------------------
// kvt_checker
// Port-level checks of the keyed value table, bound to the top level.
// ----------------------------------------------------------------------------
module kvt_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [kvt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [kvt_pkg::STATUS_W-1:0]     m_axis_tuser
);

  // One word at a time: ready drops after an accepted word
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("kvt: input ready after accepted word");

  // Stalled result word holds
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("kvt: result word changed under stall");

  // Only a found get carries a nonzero value
  a_zero_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != kvt_pkg::ST_FOUND)) |-> (m_axis_tdata == '0))
    else $error("kvt: nonzero value on a miss, insert or full result");

  // A result needs an accepted word: none right after reset ends idle
  a_no_spurious_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(!rst_ni) && rst_ni) |-> !m_axis_tvalid)
    else $error("kvt: result word without request");

endmodule

bind keyed_value_table kvt_checker u_kvt_checker (.*);

// ===== tb/keyed_value_table_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_value_table_test
// Self-checking bench for the keyed value table. A stream driver sends set
// and get words in bursts and pauses, and a monitor stalls the result stream
// on its own pattern. Each accepted word runs through a local model of the
// table (name normalization, linear match, append until full), and every
// result word is checked against the oldest predicted status and value.
// ----------------------------------------------------------------------------
module keyed_value_table_test;
  import kvt_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RANDOM_WORDS    = 800;
  localparam int DRAIN_EVERY     = 270;
  localparam int LONG_HOLD_AT    = 150;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int TAIL_CYCLES     = MAX_ENTRIES + 16;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int MAX_REPORTS     = 200;

  // One request word and one result word
  typedef struct {
    logic                      mode;
    logic [KEY_LOW_W-1:0]      key_low;
    logic [KEY_HIGH_W-1:0]     key_high;
    logic signed [VALUE_W-1:0] value;
    bit                        drain_first;
  } table_req_t;

  typedef struct {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] read_value;
  } table_rsp_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // tdata: key_low[63:0], key_high[119:64], value[183:120]
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  // tuser: mode[0]
  logic [0:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // tdata: read_value[63:0]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // tuser: status[1:0]
  logic [STATUS_W-1:0]    m_axis_tuser;

  keyed_value_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Local copy of the table contents
  logic [KEY_W-1:0]          name_tab [MAX_ENTRIES];
  logic signed [VALUE_W-1:0] val_tab  [MAX_ENTRIES];
  int                        names_held = 0;

  table_req_t       pending_reqs  [$];
  table_rsp_t       expected_rsps [$];
  logic [KEY_W-1:0] known_names   [$];

  int accepted_cnt = 0;
  int results_cnt  = 0;
  int err_cnt      = 0;
  int cycle_cnt    = 0;
  int total_reqs   = 0;

  // Clear every byte from the first zero byte on and past the name length
  function automatic logic [KEY_W-1:0] canon_name(input logic [KEY_LOW_W-1:0]  lo,
                                                  input logic [KEY_HIGH_W-1:0] hi);
    logic [KEY_W-1:0] raw;
    logic [KEY_W-1:0] res;
    bit               stop;
    raw  = {hi, lo};
    res  = '0;
    stop = 1'b0;
    for (int b = 0; b < KEY_SLOT; b++) begin
      if ((b >= KEY_BYTES) || (raw[8*b +: 8] == 8'd0)) begin
        stop = 1'b1;
      end
      if (!stop) begin
        res[8*b +: 8] = raw[8*b +: 8];
      end
    end
    return res;
  endfunction

  // Look up the name, then update, append or refuse; return the answer
  function automatic table_rsp_t table_access(input table_req_t rq);
    table_rsp_t       rsp;
    logic [KEY_W-1:0] nm;
    int               hit;
    nm  = canon_name(rq.key_low, rq.key_high);
    hit = -1;
    for (int i = 0; i < names_held; i++) begin
      if ((hit < 0) && (name_tab[i] == nm)) begin
        hit = i;
      end
    end
    rsp.read_value = '0;
    if (rq.mode == MODE_GET) begin
      if (hit >= 0) begin
        rsp.status     = ST_FOUND;
        rsp.read_value = val_tab[hit];
      end else begin
        rsp.status = ST_NOT_FOUND;
      end
    end else if (hit >= 0) begin
      val_tab[hit] = rq.value;
      rsp.status   = ST_FOUND;
    end else if (names_held >= MAX_ENTRIES) begin
      rsp.status = ST_FULL;
    end else begin
      name_tab[names_held] = nm;
      val_tab[names_held]  = rq.value;
      names_held++;
      rsp.status = ST_INSERTED;
    end
    return rsp;
  endfunction

  function automatic void queue_req(input logic mode, input logic [KEY_W-1:0] nm,
                                    input logic signed [VALUE_W-1:0] val,
                                    input bit drain);
    table_req_t rq;
    rq.mode        = mode;
    rq.key_low     = nm[KEY_LOW_W-1:0];
    rq.key_high    = nm[KEY_W-1:KEY_LOW_W];
    rq.value       = val;
    rq.drain_first = drain;
    pending_reqs.push_back(rq);
  endfunction

  // Random name of random length, sometimes with junk after the terminator, or fully random
  function automatic logic [KEY_W-1:0] fresh_name();
    logic [KEY_W-1:0] nm;
    int               len;
    bit               junk;
    nm = '0;
    if ($urandom_range(0, 6) == 0) begin
      nm = KEY_W'({$urandom, $urandom, $urandom, $urandom});
      return nm;
    end
    len  = $urandom_range(0, KEY_BYTES);
    junk = $urandom_range(0, 1);
    for (int b = 0; b < KEY_SLOT; b++) begin
      if (b < len) begin
        nm[8*b +: 8] = 8'($urandom_range(1, 255));
      end else if ((b > len) && junk) begin
        nm[8*b +: 8] = 8'($urandom);
      end
    end
    return nm;
  endfunction

  // Same name, different garbage behind the terminating zero byte
  function automatic logic [KEY_W-1:0] alias_of(input logic [KEY_W-1:0] nm);
    logic [KEY_W-1:0] res;
    int               len;
    res = canon_name(nm[KEY_LOW_W-1:0], nm[KEY_W-1:KEY_LOW_W]);
    len = 0;
    while ((len < KEY_SLOT) && (res[8*len +: 8] != 8'd0)) begin
      len++;
    end
    for (int b = len + 1; b < KEY_SLOT; b++) begin
      if ($urandom_range(0, 1)) begin
        res[8*b +: 8] = 8'($urandom);
      end
    end
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] pick_known();
    logic [KEY_W-1:0] nm;
    nm = known_names[$urandom_range(0, known_names.size() - 1)];
    if ($urandom_range(0, 1)) begin
      nm = alias_of(nm);
    end
    return nm;
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      return {1'b0, {(VALUE_W-1){1'b1}}};
    end else if (sel == 1) begin
      return {1'b1, {(VALUE_W-1){1'b0}}};
    end else if (sel == 2) begin
      return VALUE_W'($urandom_range(0, 20)) - VALUE_W'(10);
    end
    return {$urandom, $urandom};
  endfunction

  // Fill the request queue: edge cases on an empty table, then a random mix
  task automatic build_stimulus();
    logic signed [VALUE_W-1:0] vmax;
    logic signed [VALUE_W-1:0] vmin;
    logic [KEY_W-1:0]          nm;
    int                        pick;
    bit                        drain;
    vmax = {1'b0, {(VALUE_W-1){1'b1}}};
    vmin = {1'b1, {(VALUE_W-1){1'b0}}};
    // get on an empty table, then the one-byte name and the empty name
    queue_req(MODE_GET, '0, 64'sd77, 1'b0);
    queue_req(MODE_SET, KEY_W'(8'h41), vmax, 1'b0);
    queue_req(MODE_GET, KEY_W'(8'h41), '0, 1'b0);
    queue_req(MODE_SET, '0, vmin, 1'b0);
    queue_req(MODE_GET, '0, '1, 1'b0);
    // leading zero byte with junk behind it is still the empty name
    queue_req(MODE_GET, KEY_W'(64'hDEAD_BEEF_1234_5600), '0, 1'b0);
    // full-length name of all ones
    queue_req(MODE_SET, '1, -64'sd1, 1'b0);
    queue_req(MODE_GET, '1, '0, 1'b0);
    // seven bytes then a zero: a different, absent name
    queue_req(MODE_GET, {{KEY_HIGH_W{1'b1}}, 64'h00FF_FFFF_FFFF_FFFF}, '0, 1'b0);
    queue_req(MODE_SET, {{KEY_HIGH_W{1'b1}}, 64'h00FF_FFFF_FFFF_FFFF}, 64'sd3, 1'b0);
    queue_req(MODE_GET, KEY_W'(64'h00FF_FFFF_FFFF_FFFF), '0, 1'b0);
    // overwrite an existing entry
    queue_req(MODE_SET, KEY_W'(8'h41), '0, 1'b0);
    queue_req(MODE_GET, KEY_W'(8'h41), vmax, 1'b0);
    // stored with junk after the terminator, found by the clean name
    queue_req(MODE_SET, KEY_W'(64'h5A5A_5A5A_5A00_4241), 64'sd5, 1'b0);
    queue_req(MODE_GET, KEY_W'(16'h4241), '0, 1'b0);
    queue_req(MODE_GET, KEY_W'(8'h42), '0, 1'b0);
    // one-byte name with the top bit of the last byte set as junk behind the terminator
    queue_req(MODE_SET, {8'h80, {(KEY_W-8){1'b0}}} | KEY_W'(8'h01), 64'sd9, 1'b0);
    queue_req(MODE_GET, KEY_W'(8'h01), '0, 1'b0);
    known_names.push_back(KEY_W'(8'h41));
    known_names.push_back('0);
    known_names.push_back('1);
    known_names.push_back(KEY_W'(16'h4241));

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick  = $urandom_range(0, 99);
      drain = (n == 0) || ((n % DRAIN_EVERY) == DRAIN_EVERY - 1);
      if (pick < 15) begin
        nm = fresh_name();
        known_names.push_back(nm);
        queue_req(MODE_SET, nm, rand_value(), drain);
      end else if (pick < 45) begin
        queue_req(MODE_SET, pick_known(), rand_value(), drain);
      end else if (pick < 85) begin
        queue_req(MODE_GET, pick_known(), rand_value(), drain);
      end else begin
        queue_req(MODE_GET, fresh_name(), rand_value(), drain);
      end
    end
  endtask

  // Driver: present words in bursts, predict on acceptance
  table_req_t cur_req;
  bit         drv_offer;
  bit         drv_took;
  int         burst_left = 0;
  int         gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      drv_offer = s_axis_tvalid;
      drv_took  = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_rsps.push_back(table_access(cur_req));
        accepted_cnt <= accepted_cnt + 1;
        drv_offer = 1'b0;
        drv_took  = 1'b1;
      end
      if (!drv_offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if ((pending_reqs.size() > 0) &&
                     (!pending_reqs[0].drain_first ||
                      (!drv_took && (accepted_cnt == results_cnt)))) begin
          cur_req = pending_reqs.pop_front();
          s_axis_tdata <= {cur_req.value, cur_req.key_high, cur_req.key_low};
          s_axis_tuser <= cur_req.mode;
          drv_offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            case ($urandom_range(0, 9))
              0, 1, 2: gap_left = 0;
              3:       gap_left = $urandom_range(30, 90);
              default: gap_left = $urandom_range(1, 25);
            endcase
          end
        end
      end
      s_axis_tvalid <= drv_offer;
    end
  end

  // Monitor: check result words and stall the output stream
  table_rsp_t want;
  bit         rx_ready;
  bit         long_hold_done = 1'b0;
  int         hold_left      = 0;
  logic [9:0] rx_cyc         = '0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_cnt <= results_cnt + 1;
        if (expected_rsps.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("%0t: unexpected result word, expected none, got status %0d value %0d",
                     $time, m_axis_tuser, $signed(m_axis_tdata));
          end
        end else begin
          want = expected_rsps.pop_front();
          if (m_axis_tuser !== want.status) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
              $display("%0t: status mismatch, expected %0d, got %0d",
                       $time, want.status, m_axis_tuser);
            end
          end
          if (m_axis_tdata !== want.read_value) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
              $display("%0t: read_value mismatch, expected %0d, got %0d",
                       $time, want.read_value, $signed(m_axis_tdata));
            end
          end
        end
      end

      // one long hold-off while the sender keeps going, then a rotating pattern
      rx_cyc <= rx_cyc + 10'd1;
      if (!long_hold_done && (results_cnt == LONG_HOLD_AT)) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_ready = 1'b0;
      end else begin
        case (rx_cyc[9:8])
          2'd0: rx_ready = 1'b1;
          2'd1: rx_ready = ($urandom_range(0, 99) < 70);
          2'd2: begin
            rx_ready = 1'b1;
            if ($urandom_range(0, 15) == 0) begin
              hold_left = $urandom_range(1, 20);
            end
          end
          default: rx_ready = rx_cyc[0];
        endcase
      end
      m_axis_tready <= rx_ready;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("keyed_value_table_test NOT OK");
      $finish;
    end
  end

  // Sequence the run: stimulus, reset, drain, verdict
  initial begin
    build_stimulus();
    total_reqs = pending_reqs.size();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // wait for one result word per queued request word
    while (results_cnt < total_reqs) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_rsps.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d result words still expected, got none", $time,
               expected_rsps.size());
    end
    if (err_cnt == 0) begin
      $display("keyed_value_table_test OK");
    end else begin
      $display("keyed_value_table_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== keyed_value_table.f =====
sv/kvt_pkg.sv
sv/kvt_store.sv
sv/kvt_ctrl.sv
sv/keyed_value_table.sv
sv/kvt_checker.sv
tb/keyed_value_table_test.sv
